>>> rtl/peq_pkg.sv
// Shared types, constants and helper functions for the priority event queue.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package peq_pkg;

  localparam int PRIORITIES     = 4;
  localparam int DEPTH_PER_PRIO = 8;
  localparam int MAX_TYPES      = 16;
  localparam int PAYLOAD_BYTES  = 4;

  localparam int PRIO_W      = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
  localparam int PTR_W       = $clog2(DEPTH_PER_PRIO);
  localparam int ADDR_W      = PRIO_W + PTR_W;
  localparam int STORE_WORDS = 2 ** ADDR_W;

  localparam logic [PRIO_W-1:0] CURSOR_RESET = PRIO_W'((PRIORITIES > 1) ? 1 : 0);
  localparam logic [7:0] BURST_RESET = 8'd8;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_INVALID      = 3'd1;
  localparam logic [2:0] ST_UNREGISTERED = 3'd2;
  localparam logic [2:0] ST_FULL         = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE    = 3'd4;
  localparam logic [2:0] ST_EMPTY        = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [4:0]  event_type;
    logic [2:0]  priority_req;
    logic [15:0] origin_id;
    logic [2:0]  payload_length;
    logic [31:0] payload;
  } peq_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  out_type;
    logic [1:0]  out_priority;
    logic [15:0] out_source;
    logic [2:0]  out_length;
    logic [31:0] out_payload;
    logic [31:0] dropped_count;
  } peq_rsp_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] src;
    logic [2:0]  nbytes;
    logic [31:0] data;
  } peq_entry_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic load_out;
  } peq_cmd_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH_PER_PRIO - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 4; b++) begin
      m[8*b +: 8] = (n > 3'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/peq_if.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on peq_pkg for the payload types.
`default_nettype none

interface peq_req_if import peq_pkg::*;;
  logic     valid;
  logic     ready;
  peq_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface peq_rsp_if import peq_pkg::*;;
  logic     valid;
  logic     ready;
  peq_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/priority_event_queue_fair_pop.sv
// Top level: APB register file, controller and datapath of the event queue.
// Depends on peq_pkg, peq_req_if, peq_rsp_if, peq_ctrl and peq_dpath.
//
// Each request (push or pop) passes through three steps: the one in which it is
// transferred and captured, one to check, update the ring pointers and access
// the event store, and one to load the result register from the store's
// registered read port, which waits while the previous result is not taken.
// One request is in flight at a time; the next is
// taken in the cycle after the result is loaded, while that result may still
// wait in the output register. Registers: registered_types at 0x0,
// burst_limit at 0x4; write them only while the block is idle.
`default_nettype none

module priority_event_queue_fair_pop import peq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  peq_req_if.sink     req,
  peq_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_TYPES = 1'b0;
  localparam logic REG_BURST = 1'b1;

  logic [15:0] registered_types;
  logic [7:0]  burst_limit;
  logic        cfg_wr;
  peq_cmd_t    cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      registered_types <= '0;
      burst_limit      <= BURST_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TYPES: registered_types <= pwdata[15:0];
        REG_BURST: burst_limit      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TYPES: prdata = {16'b0, registered_types};
      REG_BURST: prdata = {24'b0, burst_limit};
      default:   prdata = '0;
    endcase
  end

  peq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  peq_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .req_data         (req.payload),
    .registered_types (registered_types),
    .burst_limit      (burst_limit),
    .rsp_data         (rsp.payload)
  );

endmodule

`default_nettype wire

>>> rtl/peq_ctrl.sv
// Sequencing state machine: accept, execute, load result register.
// Depends on peq_pkg for the command struct.
`default_nettype none

module peq_ctrl import peq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output peq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;

  assign req_ready    = (state == S_IDLE);
  assign rsp_valid    = out_valid;
  assign cmd.load     = req_valid && req_ready;
  assign cmd.exec     = (state == S_EXEC);
  assign cmd.load_out = (state == S_DONE) && (!out_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_DONE;
      S_DONE: begin
        if (cmd.load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EXEC))
    else $error("accepted request did not enter execute");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || rsp_ready))
    else $error("result register overwritten before transfer");

  a_result_follows_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (state == S_DONE) && !cmd.exec)
    else $error("execute not followed by result stage");

  a_out_fell: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(rsp_ready))
    else $error("result dropped without transfer");

endmodule

`default_nettype wire

>>> rtl/peq_dpath.sv
// Datapath: ring pointers, event store, arbitration and result register.
// Depends on peq_pkg; driven by peq_ctrl commands.
`default_nettype none

module peq_dpath import peq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  peq_cmd_t    cmd,
  input  peq_req_t    req_data,
  input  logic [15:0] registered_types,
  input  logic [7:0]  burst_limit,
  output peq_rsp_t    rsp_data
);

  peq_req_t          item;
  logic [PTR_W-1:0]  rd_ptr [PRIORITIES];
  logic [PTR_W-1:0]  wr_ptr [PRIORITIES];
  logic [7:0]        burst_cnt;
  logic [PRIO_W-1:0] cursor;
  logic [31:0]       drop_cnt;
  logic [2:0]        res_status;
  logic [PRIO_W-1:0] res_prio;
  logic              res_hit;
  peq_entry_t        mem [STORE_WORDS];
  peq_entry_t        rdata;
  peq_rsp_t          rsp_q;

  logic [PRIORITIES-1:0] nonempty;
  logic                  any_ne;
  logic [PRIO_W-1:0]     strict_sel;
  logic [PRIO_W-1:0]     fair_sel;
  logic [PRIO_W-1:0]     pop_sel;
  logic [PRIO_W-1:0]     cursor_next;
  logic [PRIO_W:0]       sum;
  logic                  fair;
  logic [PRIO_W-1:0]     prio_i;
  logic                  invalid;
  logic                  unreg;
  logic                  full;
  logic                  too_large;
  logic                  push_ok;
  logic                  pop_hit;
  logic [2:0]            status;
  peq_entry_t            wdata;

  always_comb begin
    any_ne     = 1'b0;
    strict_sel = '0;
    fair_sel   = '0;
    sum        = '0;
    for (int q = 0; q < PRIORITIES; q++) begin
      nonempty[q] = (rd_ptr[q] != wr_ptr[q]);
    end
    for (int q = PRIORITIES - 1; q >= 0; q--) begin
      if (nonempty[q]) begin
        any_ne     = 1'b1;
        strict_sel = PRIO_W'(q);
      end
    end
    for (int k = PRIORITIES - 1; k >= 0; k--) begin
      sum = {1'b0, cursor} + (PRIO_W + 1)'(k);
      if (sum >= (PRIO_W + 1)'(PRIORITIES)) sum = sum - (PRIO_W + 1)'(PRIORITIES);
      if (nonempty[sum[PRIO_W-1:0]]) fair_sel = sum[PRIO_W-1:0];
    end
    fair    = (burst_cnt >= burst_limit);
    pop_sel = fair ? fair_sel : strict_sel;
    sum     = {1'b0, pop_sel} + 1'b1;
    if (sum >= (PRIO_W + 1)'(PRIORITIES)) sum = sum - (PRIO_W + 1)'(PRIORITIES);
    cursor_next = sum[PRIO_W-1:0];
  end

  assign prio_i    = item.priority_req[PRIO_W-1:0];
  assign invalid   = (item.event_type >= 5'(MAX_TYPES))
                     || ({1'b0, item.priority_req} >= 4'(PRIORITIES));
  assign unreg     = !registered_types[item.event_type[3:0]];
  assign full      = (ptr_next(wr_ptr[prio_i]) == rd_ptr[prio_i]);
  assign too_large = (item.payload_length > 3'(PAYLOAD_BYTES));
  assign push_ok   = (item.operation == OP_PUSH) && !invalid && !unreg && !full
                     && !too_large;
  assign pop_hit   = (item.operation == OP_POP) && any_ne;

  always_comb begin
    if (item.operation == OP_POP) begin
      status = any_ne ? ST_OK : ST_EMPTY;
    end else if (invalid) begin
      status = ST_INVALID;
    end else if (unreg) begin
      status = ST_UNREGISTERED;
    end else if (full) begin
      status = ST_FULL;
    end else if (too_large) begin
      status = ST_TOO_LARGE;
    end else begin
      status = ST_OK;
    end
  end

  assign wdata.kind   = item.event_type[3:0];
  assign wdata.src    = item.origin_id;
  assign wdata.nbytes = item.payload_length;
  assign wdata.data   = item.payload & byte_mask(item.payload_length);

  always_ff @(posedge clk) begin
    if (cmd.load) item <= req_data;
    if (cmd.exec) begin
      res_status <= status;
      res_prio   <= pop_sel;
      res_hit    <= pop_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < PRIORITIES; q++) begin
        rd_ptr[q] <= '0;
        wr_ptr[q] <= '0;
      end
      burst_cnt <= '0;
      cursor    <= CURSOR_RESET;
      drop_cnt  <= '0;
    end else if (cmd.exec) begin
      if (item.operation == OP_PUSH) begin
        if (status == ST_FULL) drop_cnt <= drop_cnt + 1'b1;
        if (push_ok) wr_ptr[prio_i] <= ptr_next(wr_ptr[prio_i]);
      end else if (pop_hit) begin
        rd_ptr[pop_sel] <= ptr_next(rd_ptr[pop_sel]);
        if (fair) begin
          cursor    <= cursor_next;
          burst_cnt <= '0;
        end else begin
          burst_cnt <= burst_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) mem[{prio_i, wr_ptr[prio_i]}] <= wdata;
    if (cmd.exec && pop_hit) rdata <= mem[{pop_sel, rd_ptr[pop_sel]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_q.status        <= res_status;
      rsp_q.dropped_count <= drop_cnt;
      if (res_hit) begin
        rsp_q.out_type     <= rdata.kind;
        rsp_q.out_priority <= 2'(res_prio);
        rsp_q.out_source   <= rdata.src;
        rsp_q.out_length   <= rdata.nbytes;
        rsp_q.out_payload  <= rdata.data;
      end else begin
        rsp_q.out_type     <= '0;
        rsp_q.out_priority <= '0;
        rsp_q.out_source   <= '0;
        rsp_q.out_length   <= '0;
        rsp_q.out_payload  <= '0;
      end
    end
  end

  assign rsp_data = rsp_q;

  a_drop_only_on_exec: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.exec) |-> $stable(drop_cnt))
    else $error("drop counter moved outside execute");

endmodule

`default_nettype wire
